// ----- src/positional_list_engine_assert.svh -----
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// concurrent assertion shorthands used by the port checker
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("positional list engine check failed");

// next-cycle implication, disabled while reset is low
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("positional list engine check failed");

`endif

// ----- src/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// types and codes shared by the positional list engine and its cells
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int OCC_W  = 6;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_DUMP   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   slot;   // insert/remove slot, or last occupied slot for rotate
    } t_cell_cmd;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } t_in_beat;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  entry_value;
        logic                      last;
        logic [OCC_W-1:0]          occupancy;
    } t_out_beat;

endpackage

// ----- src/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds an entry and shifts it to or from its neighbours
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  ple_pkg::t_cell_cmd               i_cmd,
    input  logic signed [ple_pkg::DATA_W-1:0] i_prev,
    input  logic signed [ple_pkg::DATA_W-1:0] i_next,
    input  logic signed [ple_pkg::DATA_W-1:0] i_head,
    input  logic signed [ple_pkg::DATA_W-1:0] i_value,
    output logic signed [ple_pkg::DATA_W-1:0] o_data
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (MY_IDX == i_cmd.slot) begin
                    n_data = i_value;
                end else if (MY_IDX > i_cmd.slot) begin
                    n_data = i_prev;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= i_cmd.slot) begin
                    n_data = i_next;
                end
            end
            CELL_ROTATE: begin
                // occupied cells turn one step towards the head, head wraps to the tail
                if (MY_IDX == i_cmd.slot) begin
                    n_data = i_head;
                end else if (MY_IDX < i_cmd.slot) begin
                    n_data = i_next;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- src/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values with positional insert, remove, dump
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready, payload i_in) takes one request per
// beat: insert at a 1-based position, remove at a position, or dump the list.
// output channel (o_out_valid / i_out_ready, payload o_out) gives results.
// insert, remove, errors and the unused request code give one result beat,
// registered, in the cycle after the request beat.
// a dump of n entries gives n beats, one per cycle while the receiver takes
// them, after the dump flag is set; last marks the final beat. the list
// sits in a row of cells that turns one step per dump beat and is back in
// order when the dump ends. a new request is taken every cycle while no
// dump is running and the output register is free or being emptied; during
// a dump o_in_ready stays low. a stalled receiver holds the output beat and
// the cells keep still. reset empties the list and drops any pending result;
// slot contents are left as they were and are never read past the fill count.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ple_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ple_pkg::t_out_beat o_out
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_dump;
    logic                     n_dump;
    logic [CNT_W-1:0]         r_dump_idx;
    logic [CNT_W-1:0]         n_dump_idx;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_out_beat                r_out;
    t_out_beat                n_out;

    t_cell_cmd                w_cmd;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic [CNT_W-1:0]         w_last_idx;
    logic [POS_W:0]           w_pos_ext;
    logic [POS_W:0]           w_cnt_ext;
    logic [POS_W-1:0]         w_slot;
    logic                     w_out_free;
    logic                     w_in_fire;
    logic                     w_dump_fire;
    logic                     w_dump_last;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_dump && w_out_free;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_dump_fire = r_dump && w_out_free;

    assign w_last_idx  = r_count - CNT_W'(1);
    assign w_pos_ext   = {1'b0, i_in.position};
    assign w_cnt_ext   = (POS_W + 1)'(r_count);
    assign w_slot      = i_in.position - POS_W'(1);
    assign w_dump_last = (r_dump_idx == w_last_idx);

    always_comb begin
        n_count     = r_count;
        n_dump      = r_dump;
        n_dump_idx  = r_dump_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_cmd.op    = CELL_HOLD;
        w_cmd.slot  = '0;

        if (w_in_fire) begin
            n_out_valid       = 1'b1;
            n_out.status      = ST_OK;
            n_out.entry_value = '0;
            n_out.last        = 1'b1;
            case (i_in.req_type)
                REQ_INSERT: begin
                    if (i_in.position == '0 || w_pos_ext > w_cnt_ext + (POS_W + 1)'(1)) begin
                        n_out.status = ST_BAD_POS;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_cmd.op   = CELL_INSERT;
                        w_cmd.slot = w_slot;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
                REQ_REMOVE: begin
                    if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else if (i_in.position == '0 || w_pos_ext > w_cnt_ext) begin
                        n_out.status = ST_BAD_POS;
                    end else begin
                        w_cmd.op   = CELL_REMOVE;
                        w_cmd.slot = w_slot;
                        n_count    = r_count - CNT_W'(1);
                    end
                end
                REQ_DUMP: begin
                    if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        // beats follow from the dump sequence
                        n_out_valid = 1'b0;
                        n_dump      = 1'b1;
                        n_dump_idx  = '0;
                    end
                end
                default: n_out.status = ST_OK;
            endcase
            n_out.occupancy = OCC_W'(n_count);
        end else if (w_dump_fire) begin
            n_out_valid       = 1'b1;
            n_out.status      = ST_OK;
            n_out.entry_value = w_data[0];
            n_out.last        = w_dump_last;
            n_out.occupancy   = OCC_W'(r_count);
            w_cmd.op          = CELL_ROTATE;
            w_cmd.slot        = POS_W'(w_last_idx);
            n_dump_idx        = r_dump_idx + CNT_W'(1);
            if (w_dump_last) begin
                n_dump = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dump      <= 1'b0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_dump      <= n_dump;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;

        if (g == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_body
            assign w_prev = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_data[g+1];
        end

        ple_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_data[0]),
            .i_value (i_in.value),
            .o_data  (w_data[g])
        );
    end

endmodule

// ----- src/ple_checker.sv -----
// ----------------------------------------------------------------------------
// ple_checker
// port-level checks on the positional list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module ple_checker #(
    parameter int CAPACITY = 32
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ple_pkg::t_out_beat o_out
);
    import ple_pkg::*;

    // a stalled result beat stays put
    `PLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

    // only dump beats can be non-final, and those are always ok
    `PLE_ASSERT_NOW(a_nonlast_ok, i_clk, i_rst_n, o_out_valid && !o_out.last, o_out.status == ST_OK)

    // error beats carry no entry
    `PLE_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out.status != ST_OK, o_out.entry_value == '0)

    `PLE_ASSERT_NOW(a_occ_range, i_clk, i_rst_n, o_out_valid && CAPACITY < 64, o_out.occupancy <= OCC_W'(CAPACITY))

    // no new request while a non-final dump beat is on show
    `PLE_ASSERT_NOW(a_dump_blocks, i_clk, i_rst_n, o_out_valid && !o_out.last, !o_in_ready)

endmodule

bind positional_list_engine ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
